// ===== rtl/vhpp_pkg.sv =====
package vhpp_pkg;

    // Width of the saturating error counter.
    localparam int ERR_BITS = 16;

    // Widths of the result fields.
    localparam int STATUS_W = 4;
    localparam int KBPS_W   = 23;

    // Result tdata: all result fields packed, padded to whole bytes.
    localparam int RES_BITS  = STATUS_W + 8 + 32 + 3 * KBPS_W + 4 + 4 + 16;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    // Division by 1000 as a multiply by 2^38 / 1000, rounded up.
    // The rounding error times any 32-bit value stays below 2^38 / 1000, so the
    // truncated product is the exact floor quotient.
    localparam int          RECIP_SHIFT = 38;
    localparam logic [28:0] RECIP_MULT  = 29'd274877907;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDENT_OK   = 4'd0,
        ST_COMMENT    = 4'd1,
        ST_SETUP      = 4'd2,
        ST_BAD_TYPE   = 4'd3,
        ST_REPEAT_ID  = 4'd4,
        ST_VERSION    = 4'd5,
        ST_ZERO_FIELD = 4'd6,
        ST_BLOCKSIZE  = 4'd7,
        ST_FRAMING    = 4'd8,
        ST_TRUNCATED  = 4'd9
    } t_status;

    // Packet type codes.
    localparam logic [7:0] PKT_IDENT   = 8'h01;
    localparam logic [7:0] PKT_COMMENT = 8'h03;
    localparam logic [7:0] PKT_SETUP   = 8'h05;

    // Block size exponent limits.
    localparam logic [3:0] BLK_EXP_MIN = 4'd6;
    localparam logic [3:0] BLK_EXP_MAX = 4'd13;

    // Request to the kbps converter: one raw bitrate and the slot it fills.
    typedef struct packed {
        logic        valid;
        logic [1:0]  slot;
        logic [31:0] raw;
    } t_kbps_req;

    // Converted bitrate written back to the slot.
    typedef struct packed {
        logic              valid;
        logic [1:0]        slot;
        logic [KBPS_W-1:0] kbps;
    } t_kbps_wr;

endpackage

// ===== rtl/vhpp_kbps_div.sv =====
module vhpp_kbps_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vhpp_pkg::t_kbps_req i_req,
    output vhpp_pkg::t_kbps_wr  o_wr
);
    import vhpp_pkg::*;

    logic        r_p_valid;
    logic [1:0]  r_p_slot;
    logic        r_p_ones;
    logic [60:0] r_p_prod;

    // The product by the reciprocal is registered, and the quotient bits are
    // taken from it on the way out, in the cycle after the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_req.valid;
        end
        r_p_slot <= i_req.slot;
        r_p_ones <= (i_req.raw == 32'hFFFF_FFFF);
        r_p_prod <= 61'(i_req.raw) * 61'(RECIP_MULT);
    end

    always_comb begin
        o_wr.valid = r_p_valid;
        o_wr.slot  = r_p_slot;
        // An all-ones field means the bitrate is not given.
        o_wr.kbps  = r_p_ones ? '0 : r_p_prod[RECIP_SHIFT +: KBPS_W];
    end

endmodule

// ===== rtl/vorbis_header_packet_parser_core.sv =====
// Vorbis header packet parser.
//
// The slave channel carries header packet bytes, signature already removed,
// one byte per transfer in tdata. tuser flags the packet type byte that opens
// a packet and tlast flags the last byte of a packet. The master channel
// carries one result per finished or failed header: a status code, the
// identification header fields (valid for status 0, zero otherwise) and the
// saturating count of invalid packets seen so far.
//
// Every byte is handled in the cycle it is transferred, so the block takes
// one byte per clock. A result appears on the master channel the cycle after
// the byte that causes it. The only stall path is the result register: while
// it holds a result the receiver has not taken, tready on the slave side
// drops, and it rises again in the same cycle the receiver takes the result.
// The three bitrates are converted to kbps by a reciprocal multiplier with one
// register stage; each converted value passes that register and is then stored
// in its slot register, before the framing byte can arrive.
//
// A synchronous active-low reset clears the parser state, the error count
// and the result valid flag; no result is pending after reset.
module vorbis_header_packet_parser_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // Fields from bit 0: data_byte[7:0].
    input  logic [7:0]                       i_s_axis_tdata,
    // Fields from bit 0: packet_start.
    input  logic                             i_s_axis_tuser,
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // Fields from bit 0: status[3:0], channel_count[7:0], sample_rate[31:0],
    // bitrate_max_kbps[22:0], bitrate_nominal_kbps[22:0],
    // bitrate_min_kbps[22:0], short_block_exponent[3:0],
    // long_block_exponent[3:0], error_total[15:0], zero padding.
    output logic [vhpp_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);
    import vhpp_pkg::*;

    // Byte positions after the type byte where a field completes.
    localparam logic [4:0] POS_VERSION  = 5'd3;
    localparam logic [4:0] POS_CHANNELS = 5'd4;
    localparam logic [4:0] POS_RATE     = 5'd8;
    localparam logic [4:0] POS_BR_MAX   = 5'd12;
    localparam logic [4:0] POS_BR_NOM   = 5'd16;
    localparam logic [4:0] POS_BR_MIN   = 5'd20;
    localparam logic [4:0] POS_BLOCK    = 5'd21;
    localparam logic [4:0] POS_FRAMING  = 5'd22;

    localparam logic [ERR_BITS-1:0] ERR_TOP = '1;

    // Parser state.
    logic [4:0]          r_pos, n_pos;
    logic                r_parsing, n_parsing;
    logic                r_ident_seen, n_ident_seen;
    logic [31:0]         r_shift, n_shift;
    logic [7:0]          r_chan, n_chan;
    logic [31:0]         r_rate, n_rate;
    logic [7:0]          r_block, n_block;
    logic [ERR_BITS-1:0] r_err, n_err;
    logic [KBPS_W-1:0]   r_kbps [3];

    // Result register.
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic      s_fire;
    logic      emit;
    t_status   emit_code;
    t_kbps_req div_req;
    t_kbps_wr  div_wr;

    logic [31:0]        shift_new;
    logic [3:0]         blk_s, blk_l;
    logic [31:0]        err_ext;
    logic [15:0]        err_total;
    logic [RES_BITS-1:0] res_bits;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    assign shift_new = {i_s_axis_tdata, r_shift[31:8]};
    assign blk_s     = i_s_axis_tdata[3:0];
    assign blk_l     = i_s_axis_tdata[7:4];

    always_comb begin
        n_pos        = r_pos;
        n_parsing    = r_parsing;
        n_ident_seen = r_ident_seen;
        n_shift      = r_shift;
        n_chan       = r_chan;
        n_rate       = r_rate;
        n_block      = r_block;
        n_err        = r_err;
        emit         = 1'b0;
        emit_code    = ST_IDENT_OK;
        div_req      = '0;
        div_req.raw  = shift_new;
        div_req.slot = 2'(r_pos[4:2] - 3'd3);

        if (s_fire && i_s_axis_tuser) begin
            // A type byte always restarts the parse, dropping any open header.
            n_parsing = 1'b0;
            n_pos     = '0;
            n_shift   = '0;
            case (i_s_axis_tdata)
                PKT_IDENT: begin
                    if (r_ident_seen) begin
                        emit      = 1'b1;
                        emit_code = ST_REPEAT_ID;
                    end else if (i_s_axis_tlast) begin
                        emit      = 1'b1;
                        emit_code = ST_TRUNCATED;
                    end else begin
                        n_parsing = 1'b1;
                    end
                end
                PKT_COMMENT: begin
                    emit      = 1'b1;
                    emit_code = ST_COMMENT;
                end
                PKT_SETUP: begin
                    emit      = 1'b1;
                    emit_code = ST_SETUP;
                end
                default: begin
                    emit      = 1'b1;
                    emit_code = ST_BAD_TYPE;
                end
            endcase
        end else if (s_fire && r_parsing) begin
            n_shift = shift_new;
            case (r_pos)
                POS_VERSION: begin
                    if (shift_new != 32'd0) begin
                        emit      = 1'b1;
                        emit_code = ST_VERSION;
                    end
                end
                POS_CHANNELS: n_chan = i_s_axis_tdata;
                POS_RATE: begin
                    n_rate = shift_new;
                    if (r_chan == 8'd0 || shift_new == 32'd0) begin
                        emit      = 1'b1;
                        emit_code = ST_ZERO_FIELD;
                    end
                end
                POS_BR_MAX, POS_BR_NOM, POS_BR_MIN: div_req.valid = 1'b1;
                POS_BLOCK: begin
                    n_block = i_s_axis_tdata;
                    if (blk_s > blk_l || blk_s < BLK_EXP_MIN || blk_l < BLK_EXP_MIN
                        || blk_s > BLK_EXP_MAX || blk_l > BLK_EXP_MAX) begin
                        emit      = 1'b1;
                        emit_code = ST_BLOCKSIZE;
                    end
                end
                POS_FRAMING: begin
                    emit      = 1'b1;
                    n_parsing = 1'b0;
                    if (!i_s_axis_tdata[0]) begin
                        emit_code = ST_FRAMING;
                    end else begin
                        emit_code    = ST_IDENT_OK;
                        n_ident_seen = 1'b1;
                    end
                end
                default: ;
            endcase

            if (emit) begin
                n_parsing = 1'b0;
            end else begin
                n_pos = r_pos + 5'd1;
                if (i_s_axis_tlast) begin
                    n_parsing = 1'b0;
                    emit      = 1'b1;
                    emit_code = ST_TRUNCATED;
                end
            end
        end

        // Every failed check counts, a short packet and the reports do not.
        if (emit && emit_code != ST_IDENT_OK && emit_code != ST_COMMENT
            && emit_code != ST_SETUP && emit_code != ST_TRUNCATED && r_err != ERR_TOP) begin
            n_err = r_err + 1'b1;
        end
    end

    vhpp_kbps_div u_kbps_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_wr    (div_wr)
    );

    // The reported count is clipped to the 16-bit field.
    assign err_ext   = 32'(n_err);
    assign err_total = (err_ext > 32'h0000_FFFF) ? 16'hFFFF : err_ext[15:0];

    always_comb begin
        res_bits = '0;
        res_bits[STATUS_W-1:0] = emit_code;
        if (emit_code == ST_IDENT_OK) begin
            res_bits[RES_BITS-17:STATUS_W] = {r_block[7:4], r_block[3:0], r_kbps[2],
                                              r_kbps[1], r_kbps[0], r_rate, r_chan};
        end
        res_bits[RES_BITS-1 -: 16] = err_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_parsing    <= 1'b0;
            r_ident_seen <= 1'b0;
            r_shift      <= '0;
            r_chan       <= '0;
            r_rate       <= '0;
            r_block      <= '0;
            r_err        <= '0;
            r_kbps[0]    <= '0;
            r_kbps[1]    <= '0;
            r_kbps[2]    <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_parsing    <= n_parsing;
            r_ident_seen <= n_ident_seen;
            r_shift      <= n_shift;
            r_chan       <= n_chan;
            r_rate       <= n_rate;
            r_block      <= n_block;
            r_err        <= n_err;
            if (div_wr.valid) begin
                r_kbps[div_wr.slot] <= div_wr.kbps;
            end
            if (emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (emit) begin
            r_m_data <= M_TDATA_W'(res_bits);
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

// ===== test/tb_vorbis_header_packet_parser_core.sv =====
`timescale 1ns / 100ps

module tb_vorbis_header_packet_parser_core;
    import vhpp_pkg::*;

    // Generous cycle budget for the whole run.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Random header bytes to send after the directed part.
    localparam int RANDOM_BYTES = 550;
    // Random byte count after which the one valid ident header is sent.
    localparam int OK_AFTER = 450;
    // Byte offsets, counted after the type byte, where the ident header checks fall.
    localparam int OFS_VERSION = 3;
    localparam int OFS_CHANNELS = 4;
    localparam int OFS_RATE = 8;
    localparam int OFS_BR_MAX = 12;
    localparam int OFS_BR_NOM = 16;
    localparam int OFS_BR_MIN = 20;
    localparam int OFS_BLOCK = 21;
    localparam int OFS_FRAMING = 22;
    localparam int IDENT_BODY = 23;

    typedef logic [7:0] t_byte_q[$];

    // Ways a random ident header is spoiled so that it is not the valid one.
    typedef enum int {
        FLT_VERSION,
        FLT_ZERO,
        FLT_BLOCK,
        FLT_FRAMING,
        FLT_CUT
    } t_fault;

    // One result transfer, laid out as the master tdata packs it (status at bit 0).
    typedef struct packed {
        logic [M_TDATA_W-RES_BITS-1:0] pad;
        logic [15:0]                   errs;
        logic [3:0]                    l_exp;
        logic [3:0]                    s_exp;
        logic [KBPS_W-1:0]             kmin;
        logic [KBPS_W-1:0]             knom;
        logic [KBPS_W-1:0]             kmax;
        logic [31:0]                   rate;
        logic [7:0]                    chans;
        t_status                       status;
    } t_hdr_result;

    // Tracks the parser state on its own and holds the reports it predicts.
    class header_scoreboard;
        t_hdr_result awaited_reports[$];
        int unsigned mismatches;

        logic [4:0]          pos;
        logic                parsing;
        logic                ident_seen;
        logic [31:0]         shift;
        logic [7:0]          chans;
        logic [31:0]         rate;
        logic [31:0]         brates[3];
        logic [7:0]          blk;
        logic [ERR_BITS-1:0] errs;

        function new();
            pos = '0;
            parsing = 1'b0;
            ident_seen = 1'b0;
            shift = '0;
            chans = '0;
            rate = '0;
            foreach (brates[i]) brates[i] = '0;
            blk = '0;
            errs = '0;
            mismatches = 0;
        endfunction

        static function bit blocks_ok(logic [7:0] b);
            logic [3:0] s;
            logic [3:0] l;
            s = b[3:0];
            l = b[7:4];
            return !(s > l || s < BLK_EXP_MIN || l < BLK_EXP_MIN ||
                     s > BLK_EXP_MAX || l > BLK_EXP_MAX);
        endfunction

        static function logic [KBPS_W-1:0] to_kbps(logic [31:0] raw);
            logic [31:0] q;
            q = (raw == 32'hFFFF_FFFF) ? 32'd0 : raw / 32'd1000;
            return q[KBPS_W-1:0];
        endfunction

        function void report(t_status st);
            t_hdr_result r;
            r = '0;
            r.status = st;
            if (st == ST_IDENT_OK) begin
                r.chans = chans;
                r.rate = rate;
                r.kmax = to_kbps(brates[0]);
                r.knom = to_kbps(brates[1]);
                r.kmin = to_kbps(brates[2]);
                r.s_exp = blk[3:0];
                r.l_exp = blk[7:4];
            end
            r.errs = (32'(errs) > 32'hFFFF) ? 16'hFFFF : 16'(errs);
            awaited_reports.push_back(r);
        endfunction

        // A failed check ends the header and counts one invalid packet.
        function void reject(t_status st);
            parsing = 1'b0;
            if (errs != '1) errs = errs + 1'b1;
            report(st);
        endfunction

        // Called for every accepted input transfer.
        function void parse_byte(logic [7:0] b, logic st, logic la);
            logic [4:0] p;
            if (st) begin
                parsing = 1'b0;
                pos = '0;
                shift = '0;
                case (b)
                    PKT_IDENT: begin
                        if (ident_seen) reject(ST_REPEAT_ID);
                        else if (la) report(ST_TRUNCATED);
                        else parsing = 1'b1;
                    end
                    PKT_COMMENT: report(ST_COMMENT);
                    PKT_SETUP: report(ST_SETUP);
                    default: reject(ST_BAD_TYPE);
                endcase
                return;
            end
            if (!parsing) return;
            p = pos;
            shift = {b, shift[31:8]};
            case (int'(p))
                OFS_VERSION: begin
                    if (shift != 32'd0) begin
                        reject(ST_VERSION);
                        return;
                    end
                end
                OFS_CHANNELS: chans = b;
                OFS_RATE: begin
                    rate = shift;
                    if (chans == 8'd0 || rate == 32'd0) begin
                        reject(ST_ZERO_FIELD);
                        return;
                    end
                end
                OFS_BR_MAX: brates[0] = shift;
                OFS_BR_NOM: brates[1] = shift;
                OFS_BR_MIN: brates[2] = shift;
                OFS_BLOCK: begin
                    blk = b;
                    if (!blocks_ok(b)) begin
                        reject(ST_BLOCKSIZE);
                        return;
                    end
                end
                OFS_FRAMING: begin
                    if (!b[0]) begin
                        reject(ST_FRAMING);
                    end else begin
                        ident_seen = 1'b1;
                        parsing = 1'b0;
                        report(ST_IDENT_OK);
                    end
                    return;
                end
                default: ;
            endcase
            pos = p + 5'd1;
            if (la) begin
                parsing = 1'b0;
                report(ST_TRUNCATED);
            end
        endfunction

        function void complain(string why, t_hdr_result want, t_hdr_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s at %0t", why, $realtime);
                $display("  expected st=%0d ch=%0d rate=%0h kbps=%0d/%0d/%0d blk=%0d/%0d err=%0d",
                         want.status, want.chans, want.rate, want.kmax, want.knom,
                         want.kmin, want.s_exp, want.l_exp, want.errs);
                $display("  actual   st=%0d ch=%0d rate=%0h kbps=%0d/%0d/%0d blk=%0d/%0d err=%0d",
                         got.status, got.chans, got.rate, got.kmax, got.knom,
                         got.kmin, got.s_exp, got.l_exp, got.errs);
            end
        endfunction

        // Called for every accepted result transfer.
        function void check_report(logic [M_TDATA_W-1:0] raw);
            t_hdr_result got;
            t_hdr_result want;
            got = t_hdr_result'(raw);
            if (awaited_reports.size() == 0) begin
                complain("result with nothing expected", '0, got);
                return;
            end
            want = awaited_reports.pop_front();
            if (got.status !== want.status || got.chans !== want.chans ||
                got.rate !== want.rate || got.kmax !== want.kmax ||
                got.knom !== want.knom || got.kmin !== want.kmin ||
                got.s_exp !== want.s_exp || got.l_exp !== want.l_exp ||
                got.errs !== want.errs)
                complain("result mismatch", want, got);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            s_data = '0;
    logic                  s_user = 1'b0;
    logic                  s_last = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  m_ready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    header_scoreboard sb;
    // While calm is set neither side inserts idle cycles.
    bit calm = 1'b0;
    int sent_bytes = 0;
    int unsigned cycles = 0;

    vorbis_header_packet_parser_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // The receiver stalls at random; every result transfer is checked at the
    // rising edge where it completes.
    always @(negedge i_clk) begin
        if (calm) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 28);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) sb.check_report(o_m_axis_tdata);
    end

    // Drives one byte transfer, with random idle cycles ahead of it, and hands it
    // to the scoreboard once the block has taken it. tvalid stays high after the
    // transfer until the next call decides what the following cycle carries.
    task automatic push_byte(input logic [7:0] d, input logic st, input logic la);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        s_user <= st;
        s_last <= la;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.parse_byte(d, st, la);
        sent_bytes++;
    endtask

    // A type byte followed by its body; tlast goes on the final byte when asked.
    task automatic send_packet(input logic [7:0] ptype, input t_byte_q body, input bit with_last);
        push_byte(ptype, 1'b1, with_last && body.size() == 0);
        foreach (body[i]) push_byte(body[i], 1'b0, with_last && i == body.size() - 1);
    endtask

    task automatic rand_bytes(input int n, output t_byte_q q);
        q = {};
        repeat (n) q.push_back(8'($urandom_range(255)));
    endtask

    // Sends an ident header built from the given fields. Only the first keep body
    // bytes are sent; a complete header may carry extra bytes after its framing byte.
    task automatic send_ident(input logic [31:0] ver, input logic [7:0] ch,
                              input logic [31:0] rate, input logic [31:0] bmax,
                              input logic [31:0] bnom, input logic [31:0] bmin,
                              input logic [7:0] blk, input logic [7:0] frm,
                              input int keep, input int extra, input bit with_last);
        t_byte_q body;
        t_byte_q tail;
        logic [95:0] brs;
        body = {};
        brs = {bmin, bnom, bmax};
        for (int k = 0; k < 4; k++) body.push_back(ver[8*k +: 8]);
        body.push_back(ch);
        for (int k = 0; k < 4; k++) body.push_back(rate[8*k +: 8]);
        for (int k = 0; k < 12; k++) body.push_back(brs[8*k +: 8]);
        body.push_back(blk);
        body.push_back(frm);
        while (body.size() > keep) void'(body.pop_back());
        if (keep >= IDENT_BODY && extra > 0) begin
            rand_bytes(extra, tail);
            foreach (tail[i]) body.push_back(tail[i]);
        end
        send_packet(PKT_IDENT, body, with_last);
    endtask

    function automatic logic [31:0] pick_bitrate();
        case ($urandom_range(3))
            0: return 32'hFFFF_FFFF;
            1: return 32'hFFFF_FFFE;
            2: return $urandom;
            default: return 32'($urandom_range(2000));
        endcase
    endfunction

    // A random ident header. Unless good is set, one or two fields are spoiled or
    // the header is cut short, so that the single valid header can be placed late.
    task automatic random_ident(input bit good);
        logic [31:0] ver;
        logic [31:0] rate;
        logic [7:0]  ch;
        logic [7:0]  blk;
        logic [7:0]  frm;
        logic [3:0]  s;
        logic [3:0]  l;
        t_fault      flt;
        int          keep;
        int          extra;
        int          m;
        bit          lst;
        ver = '0;
        ch = 8'($urandom_range(1, 255));
        rate = $urandom;
        if (rate == 32'd0) rate = 32'd1;
        s = 4'($urandom_range(6, 13));
        l = 4'($urandom_range(s, 13));
        blk = {l, s};
        frm = 8'($urandom_range(255)) | 8'h01;
        keep = IDENT_BODY;
        extra = 0;
        lst = 1'b1;
        if (good) begin
            extra = $urandom_range(0, 3);
            lst = ($urandom_range(3) != 0);
        end else begin
            flt = t_fault'($urandom_range(FLT_VERSION, FLT_CUT));
            case (flt)
                FLT_VERSION: begin
                    ver = $urandom_range(1) ? (32'h1 << $urandom_range(31)) : $urandom;
                    if (ver == 32'd0) ver = 32'd1;
                end
                FLT_ZERO: begin
                    m = $urandom_range(2);
                    if (m != 1) ch = 8'd0;
                    if (m != 0) rate = 32'd0;
                end
                FLT_BLOCK: begin
                    do blk = 8'($urandom_range(255)); while (header_scoreboard::blocks_ok(blk));
                end
                FLT_FRAMING: frm = 8'($urandom_range(255)) & 8'hFE;
                default: ;
            endcase
            m = $urandom_range(9);
            if (flt == FLT_CUT || m < 4) begin
                keep = $urandom_range(0, IDENT_BODY - 1);
                lst = $urandom_range(1);
            end else if (m < 6) begin
                extra = $urandom_range(1, 3);
            end else if (m == 6) begin
                lst = 1'b0;
            end
        end
        send_ident(ver, ch, rate, pick_bitrate(), pick_bitrate(), pick_bitrate(),
                   blk, frm, keep, extra, lst);
    endtask

    // Watchdog: a run that stalls or loses results ends here.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_byte_q none;
        t_byte_q payload;
        logic [7:0] ptype;
        int base;
        int r;
        bit ok_sent;
        none = {};
        ok_sent = 1'b0;
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Stray bytes outside any packet give no result.
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        // Unknown packet types at both ends of the byte range.
        send_packet(8'h00, none, 1'b1);
        payload = {8'h12};
        send_packet(8'hFF, payload, 1'b1);
        // Comment and setup packets are reported at their type byte.
        payload = {8'h00, 8'hFF};
        send_packet(PKT_COMMENT, payload, 1'b1);
        send_packet(PKT_SETUP, none, 1'b1);
        // An ident type byte that is also the last byte is a truncated header.
        send_packet(PKT_IDENT, none, 1'b1);
        // Nonzero version, once with tlast on the failing byte itself.
        send_ident(32'h8000_0000, 8'd2, 32'd44100, 32'd0, 32'd128000, 32'd0,
                   8'hB8, 8'h01, IDENT_BODY, 0, 1'b1);
        send_ident(32'h0000_0001, 8'd2, 32'd44100, 32'd0, 32'd0, 32'd0,
                   8'hB8, 8'h01, OFS_VERSION + 1, 0, 1'b1);
        // Zero channels, then zero sample rate.
        send_ident(32'd0, 8'd0, 32'd48000, 32'd0, 32'd0, 32'd0,
                   8'hB8, 8'h01, IDENT_BODY, 0, 1'b1);
        send_ident(32'd0, 8'd1, 32'd0, 32'd0, 32'd0, 32'd0,
                   8'hB8, 8'h01, IDENT_BODY, 0, 1'b1);
        // Block sizes: short above long, short below the minimum, long above the maximum.
        send_ident(32'd0, 8'd1, 32'd8000, 32'd0, 32'd0, 32'd0,
                   8'h79, 8'h01, IDENT_BODY, 0, 1'b1);
        send_ident(32'd0, 8'd1, 32'd8000, 32'd0, 32'd0, 32'd0,
                   8'hD5, 8'h01, IDENT_BODY, 0, 1'b1);
        send_ident(32'd0, 8'd1, 32'd8000, 32'd0, 32'd0, 32'd0,
                   8'hE6, 8'h01, IDENT_BODY, 0, 1'b1);
        // Framing bit clear with every other field at its extreme.
        send_ident(32'd0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE,
                   8'hDD, 8'hFE, IDENT_BODY, 0, 1'b1);
        // Header ends early, and a header cut off by a new packet start.
        send_ident(32'd0, 8'd2, 32'd44100, 32'd0, 32'd0, 32'd0,
                   8'hB8, 8'h01, 10, 0, 1'b1);
        send_ident(32'd0, 8'd2, 32'd44100, 32'd0, 32'd0, 32'd0,
                   8'hB8, 8'h01, 5, 0, 1'b0);
        send_packet(PKT_COMMENT, none, 1'b1);

        // Random part. A long quiet stretch in the middle has no idle cycles.
        base = sent_bytes;
        while (sent_bytes - base < RANDOM_BYTES) begin
            calm = (sent_bytes - base >= 250) && (sent_bytes - base < 400);
            r = $urandom_range(99);
            if (!ok_sent && sent_bytes - base >= OK_AFTER) begin
                random_ident(1'b1);
                ok_sent = 1'b1;
            end else if (r < 55) begin
                random_ident(1'b0);
            end else if (r < 65) begin
                rand_bytes($urandom_range(0, 5), payload);
                send_packet(PKT_COMMENT, payload, $urandom_range(3) != 0);
            end else if (r < 73) begin
                rand_bytes($urandom_range(0, 5), payload);
                send_packet(PKT_SETUP, payload, $urandom_range(3) != 0);
            end else if (r < 81) begin
                do ptype = 8'($urandom_range(255));
                while (ptype == PKT_IDENT || ptype == PKT_COMMENT || ptype == PKT_SETUP);
                rand_bytes($urandom_range(0, 3), payload);
                send_packet(ptype, payload, 1'b1);
            end else if (r < 90) begin
                // Bytes without a type byte; they continue a header left open.
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(255)), 1'b0, $urandom_range(3) == 0);
            end else begin
                send_packet(PKT_IDENT, none, 1'b1);
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        s_valid <= 1'b0;

        // Drain the outstanding results, then keep watching for strays before the verdict.
        while (sb.awaited_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
